[sv/tm44_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tm44_pkg: shared types and constants for the 4x4 tile multiply-accumulate
// Number formats, request codes and the accumulator saturation helper.
// ----------------------------------------------------------------------------
package tm44_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int ACC_WIDTH  = 48;
  localparam int TILE       = 4;
  localparam int MAX_DEPTH  = 128;
  localparam int DEPTH_W    = $clog2(MAX_DEPTH);
  localparam int ROW_W      = $clog2(TILE);
  localparam int IDX_W      = $clog2(TILE * TILE);

  // request codes
  localparam logic REQ_PRELOAD = 1'b0;
  localparam logic REQ_STEP    = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0]   data_t;
  typedef logic signed [2*DATA_WIDTH-1:0] prod_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;
  typedef logic signed [ACC_WIDTH:0]      wide_t;
  typedef logic [ROW_W-1:0]               row_t;
  typedef logic [IDX_W-1:0]               idx_t;
  typedef acc_t                           row_sums_t [TILE];

  localparam acc_t ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // clamp a one-bit-wider sum back into accumulator range
  function automatic acc_t sat_acc(input wide_t v);
    acc_t r;
    if (v[ACC_WIDTH] != v[ACC_WIDTH-1]) begin
      r = v[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      r = v[ACC_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

[sv/tile_mac_4x4_top.sv]
`timescale 1ns / 1ps
// Path: a flushing step passes the input register, then row 0 shows from the
//   row buffer; rows 1..3 follow one per cycle as the output side takes them.
// Throughput: one item per cycle; a flushing step holds the row buffer for
//   four output transactions, and a second flush stalls until it drains.
// Reset: synchronous; clears accumulators, step counter and all valid flags.
// ----------------------------------------------------------------------------
// tile_mac_4x4_top: 4x4 outer-product multiply-accumulate tile
// Input register, sixteen parallel saturating MACs into the accumulators,
// and a four-row result buffer that drains one tile row per transaction.
// ----------------------------------------------------------------------------
module tile_mac_4x4_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  tm44_pkg::idx_t    c_index,
  input  tm44_pkg::acc_t    c_value,
  input  tm44_pkg::data_t   a_0,
  input  tm44_pkg::data_t   a_1,
  input  tm44_pkg::data_t   a_2,
  input  tm44_pkg::data_t   a_3,
  input  tm44_pkg::data_t   b_0,
  input  tm44_pkg::data_t   b_1,
  input  tm44_pkg::data_t   b_2,
  input  tm44_pkg::data_t   b_3,
  input  logic              last_step,
  output logic              out_valid,
  input  logic              out_stall,
  output tm44_pkg::row_t    row_index,
  output tm44_pkg::acc_t    sum_0,
  output tm44_pkg::acc_t    sum_1,
  output tm44_pkg::acc_t    sum_2,
  output tm44_pkg::acc_t    sum_3,
  output logic              last_row
);
  import tm44_pkg::*;

  // input register
  logic                st_valid;
  logic                st_req_type;
  idx_t                st_c_index;
  acc_t                st_c_value;
  data_t               st_a [TILE];
  data_t               st_b [TILE];
  logic                st_last_step;

  // accumulators and step counter
  acc_t                acc [TILE*TILE];
  acc_t                acc_next [TILE*TILE];
  acc_t                sum_new [TILE*TILE];
  logic [DEPTH_W-1:0]  step_cnt;

  // result row buffer
  logic                obuf_valid;
  row_t                obuf_row;
  acc_t                obuf [TILE][TILE];

  logic                st_flush;
  logic                out_take;
  logic                obuf_free;
  logic                take;
  logic                in_take;

  // control
  assign st_flush  = (st_req_type == REQ_STEP) &&
                     (st_last_step || (step_cnt == DEPTH_W'(MAX_DEPTH - 1)));
  assign out_take  = obuf_valid && !out_stall;
  assign obuf_free = !obuf_valid || (out_take && (obuf_row == row_t'(TILE - 1)));
  assign take      = st_valid && !(st_flush && !obuf_free);
  assign in_stall  = st_valid && !take;
  assign in_take   = in_valid && !in_stall;

  // input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_take) begin
      st_valid <= 1'b1;
    end else if (take) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      st_req_type  <= req_type;
      st_c_index   <= c_index;
      st_c_value   <= c_value;
      st_a[0]      <= a_0;
      st_a[1]      <= a_1;
      st_a[2]      <= a_2;
      st_a[3]      <= a_3;
      st_b[0]      <= b_0;
      st_b[1]      <= b_1;
      st_b[2]      <= b_2;
      st_b[3]      <= b_3;
      st_last_step <= last_step;
    end
  end

  // sixteen independent multiply and saturating adds
  always_comb begin
    prod_t p;
    p = '0;
    for (int i = 0; i < TILE; i++) begin
      for (int j = 0; j < TILE; j++) begin
        p = st_a[i] * st_b[j];
        sum_new[i*TILE + j] = sat_acc(wide_t'(acc[i*TILE + j]) + wide_t'(p));
      end
    end
  end

  // accumulator next value
  always_comb begin
    for (int k = 0; k < TILE*TILE; k++) begin
      acc_next[k] = acc[k];
    end
    if (take) begin
      if (st_req_type == REQ_PRELOAD) begin
        acc_next[st_c_index] = st_c_value;
      end else begin
        for (int k = 0; k < TILE*TILE; k++) begin
          acc_next[k] = st_flush ? '0 : sum_new[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TILE*TILE; k++) begin
        acc[k] <= '0;
      end
    end else begin
      for (int k = 0; k < TILE*TILE; k++) begin
        acc[k] <= acc_next[k];
      end
    end
  end

  // steps since the last flush
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (take && (st_req_type == REQ_STEP)) begin
      step_cnt <= st_flush ? '0 : step_cnt + 1'b1;
    end
  end

  // row buffer control: load on flush, advance on each output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
      obuf_row   <= '0;
    end else if (take && st_flush) begin
      obuf_valid <= 1'b1;
      obuf_row   <= '0;
    end else if (out_take) begin
      obuf_valid <= (obuf_row != row_t'(TILE - 1));
      obuf_row   <= obuf_row + 1'b1;
    end
  end

  // row buffer data: the head row always sits in slot 0
  always_ff @(posedge clk) begin
    if (take && st_flush) begin
      for (int i = 0; i < TILE; i++) begin
        for (int j = 0; j < TILE; j++) begin
          obuf[i][j] <= sum_new[i*TILE + j];
        end
      end
    end else if (out_take) begin
      for (int i = 0; i < TILE - 1; i++) begin
        obuf[i] <= obuf[i+1];
      end
    end
  end

  // outputs
  assign out_valid = obuf_valid;
  assign row_index = obuf_row;
  assign sum_0     = obuf[0][0];
  assign sum_1     = obuf[0][1];
  assign sum_2     = obuf[0][2];
  assign sum_3     = obuf[0][3];
  assign last_row  = (obuf_row == row_t'(TILE - 1));

  // checks
  a_flush_loads_row0 : assert property (@(posedge clk) disable iff (rst)
    take && st_flush |=> out_valid && (row_index == '0))
    else $error("flush did not present row 0");

  a_flush_clears_acc : assert property (@(posedge clk) disable iff (rst)
    take && st_flush |=> (acc[0] == '0) && (acc[TILE*TILE-1] == '0) && (step_cnt == '0))
    else $error("accumulators not cleared after flush");

  a_stall_only_on_flush : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> st_valid && st_flush && obuf_valid)
    else $error("input stalled without a pending flush");

  a_rows_in_order : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_row |=>
      out_valid && (row_index == $past(row_index) + 1'b1))
    else $error("tile rows out of order");

endmodule

[tb/tile_mac_4x4_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_mac_4x4_checker: scoreboard for the 4x4 outer-product MAC tile
// Watches both channels. It keeps its own copy of the sixteen saturating
// accumulators and the step counter, works out the four tile rows that each
// flushing step produces, and compares every row that is taken field by field.
// ----------------------------------------------------------------------------
module tile_mac_4x4_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              req_type,
  input  tm44_pkg::idx_t    c_index,
  input  tm44_pkg::acc_t    c_value,
  input  tm44_pkg::data_t   a_0,
  input  tm44_pkg::data_t   a_1,
  input  tm44_pkg::data_t   a_2,
  input  tm44_pkg::data_t   a_3,
  input  tm44_pkg::data_t   b_0,
  input  tm44_pkg::data_t   b_1,
  input  tm44_pkg::data_t   b_2,
  input  tm44_pkg::data_t   b_3,
  input  logic              last_step,
  input  logic              out_valid,
  input  logic              out_stall,
  input  tm44_pkg::row_t    row_index,
  input  tm44_pkg::acc_t    sum_0,
  input  tm44_pkg::acc_t    sum_1,
  input  tm44_pkg::acc_t    sum_2,
  input  tm44_pkg::acc_t    sum_3,
  input  logic              last_row,
  output int                fail_count,
  output int                rows_pending,
  output int                rows_checked
);
  import tm44_pkg::*;

  typedef struct packed {
    row_t                  row;
    acc_t [TILE-1:0]       sums;
    logic                  last;
  } tile_row_t;

  // predicted accumulator state and depth counter
  acc_t        tile_acc [TILE*TILE];
  int unsigned depth_count;

  // tile rows still owed by the block, oldest first
  tile_row_t   row_queue [$];

  initial begin
    fail_count   = 0;
    rows_pending = 0;
    rows_checked = 0;
  end

  // one line per mismatch, and count it
  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic acc_t clamp_to_acc(input longint v);
    if (v > longint'(ACC_MAX)) begin
      return ACC_MAX;
    end else if (v < longint'(ACC_MIN)) begin
      return ACC_MIN;
    end
    return acc_t'(v);
  endfunction

  task automatic clear_tile();
    int k;
    for (k = 0; k < TILE*TILE; k++) tile_acc[k] = '0;
    depth_count = 0;
  endtask

  // apply one accepted input transaction to the predicted tile
  task automatic accumulate_item();
    data_t     a_col [TILE];
    data_t     b_row [TILE];
    tile_row_t flushed;
    int        i;
    int        j;
    a_col = '{a_0, a_1, a_2, a_3};
    b_row = '{b_0, b_1, b_2, b_3};
    if (req_type == REQ_PRELOAD) begin
      tile_acc[c_index] = c_value;
    end else begin
      for (i = 0; i < TILE; i++) begin
        for (j = 0; j < TILE; j++) begin
          tile_acc[i*TILE+j] = clamp_to_acc(longint'(tile_acc[i*TILE+j]) +
                                            longint'(a_col[i]) * longint'(b_row[j]));
        end
      end
      if (depth_count < MAX_DEPTH) depth_count++;
      // flush on the marked step or when the depth limit is reached
      if (last_step || depth_count >= MAX_DEPTH) begin
        for (i = 0; i < TILE; i++) begin
          flushed.row = row_t'(i);
          for (j = 0; j < TILE; j++) flushed.sums[j] = tile_acc[i*TILE+j];
          flushed.last = (i == TILE - 1);
          row_queue.push_back(flushed);
        end
        clear_tile();
      end
    end
  endtask

  // compare one taken tile row with the oldest prediction
  task automatic check_row();
    tile_row_t want;
    acc_t      got [TILE];
    int        j;
    got = '{sum_0, sum_1, sum_2, sum_3};
    if (row_queue.size() == 0) begin
      report_mismatch($sformatf("row %0d arrived with no tile row outstanding", row_index));
    end else begin
      want = row_queue.pop_front();
      if (row_index !== want.row)
        report_mismatch($sformatf("row_index %0d, predicted %0d", row_index, want.row));
      for (j = 0; j < TILE; j++) begin
        if (got[j] !== want.sums[j])
          report_mismatch($sformatf("row %0d sum_%0d = %h, predicted %h",
                                    want.row, j, got[j], want.sums[j]));
      end
      if (last_row !== want.last)
        report_mismatch($sformatf("row %0d last_row = %b, predicted %b",
                                  want.row, last_row, want.last));
      rows_checked++;
    end
  endtask

  // sample both channels on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_tile();
      row_queue.delete();
    end else begin
      if (in_valid && !in_stall) accumulate_item();
      if (out_valid && !out_stall) check_row();
    end
    rows_pending = row_queue.size();
  end

endmodule

[tb/tile_mac_4x4_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_mac_4x4_top_tb: testbench for the 4x4 outer-product MAC tile
// Drives preload and step transactions with random idling on the input side
// and random stalls on the output side. A directed part covers saturation at
// both ends, ignored fields, preloads in the middle of a tile and an all-zero
// tile; a long tile without a marked last step exercises the depth limit;
// random tiles follow. The checker predicts and compares every tile row.
// ----------------------------------------------------------------------------
module tile_mac_4x4_top_tb;
  import tm44_pkg::*;

  localparam int    ITEM_TARGET  = 330;
  localparam int    CYCLE_LIMIT  = 200000;
  localparam int    DRAIN_CYCLES = 16;
  localparam int    IDLE_PCT     = 6;
  localparam data_t Q_MAX        = 16'sh7fff;
  localparam data_t Q_MIN        = -16'sh8000;

  typedef data_t [TILE-1:0] lanes_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  logic  req_type;
  idx_t  c_index;
  acc_t  c_value;
  data_t a_0, a_1, a_2, a_3;
  data_t b_0, b_1, b_2, b_3;
  logic  last_step;
  logic  out_valid;
  logic  out_stall;
  row_t  row_index;
  acc_t  sum_0, sum_1, sum_2, sum_3;
  logic  last_row;

  bit    calm;
  int    n_preloads;
  int    n_steps;
  int    cycle_count;
  int    fail_count;
  int    rows_pending;
  int    rows_checked;

  tile_mac_4x4_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .c_index   (c_index),
    .c_value   (c_value),
    .a_0       (a_0),
    .a_1       (a_1),
    .a_2       (a_2),
    .a_3       (a_3),
    .b_0       (b_0),
    .b_1       (b_1),
    .b_2       (b_2),
    .b_3       (b_3),
    .last_step (last_step),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row_index (row_index),
    .sum_0     (sum_0),
    .sum_1     (sum_1),
    .sum_2     (sum_2),
    .sum_3     (sum_3),
    .last_row  (last_row)
  );

  tile_mac_4x4_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .c_index      (c_index),
    .c_value      (c_value),
    .a_0          (a_0),
    .a_1          (a_1),
    .a_2          (a_2),
    .a_3          (a_3),
    .b_0          (b_0),
    .b_1          (b_1),
    .b_2          (b_2),
    .b_3          (b_3),
    .last_step    (last_step),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .row_index    (row_index),
    .sum_0        (sum_0),
    .sum_1        (sum_1),
    .sum_2        (sum_2),
    .sum_3        (sum_3),
    .last_row     (last_row),
    .fail_count   (fail_count),
    .rows_pending (rows_pending),
    .rows_checked (rows_checked)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // output side stalls at random, except in the calm stretch
  always @(negedge clk) begin
    out_stall = !rst && !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d tile rows outstanding", cycle_count, rows_pending);
    $display("tile_mac_4x4_top_tb failed");
    $finish;
  end

  function automatic lanes_t pack_lanes(input data_t d0, input data_t d1,
                                        input data_t d2, input data_t d3);
    return {d3, d2, d1, d0};
  endfunction

  // Q1.15 value biased towards the two extremes
  function automatic data_t rand_q15();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return Q_MAX;
    if (pick == 1) return Q_MIN;
    return data_t'($urandom);
  endfunction

  function automatic lanes_t rand_lanes();
    return pack_lanes(rand_q15(), rand_q15(), rand_q15(), rand_q15());
  endfunction

  // accumulator value: extremes, small values or full-range noise
  function automatic acc_t rand_acc();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return ACC_MAX;
    if (pick == 1) return ACC_MIN;
    if (pick == 2) return acc_t'(longint'($urandom_range(0, 4000)) - 2000);
    return acc_t'({$urandom, $urandom});
  endfunction

  // one transaction: optional idle gap, then hold until accepted
  task automatic send_item(input logic rq, input idx_t idx, input acc_t val,
                           input lanes_t col, input lanes_t row, input logic lst);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid  = 1'b0;
      req_type  = logic'($urandom);
      last_step = logic'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    req_type  = rq;
    c_index   = idx;
    c_value   = val;
    {a_3, a_2, a_1, a_0} = col;
    {b_3, b_2, b_1, b_0} = row;
    last_step = lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (rq == REQ_PRELOAD) n_preloads++;
    else n_steps++;
  endtask

  // preload with junk in the step fields
  task automatic send_preload(input idx_t idx, input acc_t val);
    send_item(REQ_PRELOAD, idx, val, rand_lanes(), rand_lanes(), logic'($urandom));
  endtask

  // step with junk in the preload fields
  task automatic send_step(input lanes_t col, input lanes_t row, input logic lst);
    send_item(REQ_STEP, idx_t'($urandom), rand_acc(), col, row, lst);
  endtask

  // random tile: preloads, a few steps, the odd preload mid-tile,
  // and now and then no marked last step so the tile runs on
  task automatic run_random_tile();
    int n_pre;
    int n_run;
    int k;
    bit ends;
    n_pre = ($urandom_range(0, 2) == 0) ? TILE*TILE : $urandom_range(0, 6);
    for (k = 0; k < n_pre; k++)
      send_preload((n_pre == TILE*TILE) ? idx_t'(k) : idx_t'($urandom), rand_acc());
    n_run = $urandom_range(1, 8);
    ends  = ($urandom_range(0, 9) != 0);
    for (k = 0; k < n_run; k++) begin
      if ($urandom_range(0, 11) == 0) send_preload(idx_t'($urandom), rand_acc());
      send_step(rand_lanes(), rand_lanes(), ends && (k == n_run - 1));
    end
  endtask

  initial begin
    int k;
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = REQ_PRELOAD;
    c_index    = '0;
    c_value    = '0;
    {a_3, a_2, a_1, a_0} = '0;
    {b_3, b_2, b_1, b_0} = '0;
    last_step  = 1'b0;
    calm       = 1'b0;
    n_preloads = 0;
    n_steps    = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // positive saturation, ignored fields on both kinds of transaction
    send_preload(idx_t'(0), ACC_MAX);
    send_preload(idx_t'(5), ACC_MIN);
    send_preload(idx_t'(15), acc_t'(-1));
    send_item(REQ_PRELOAD, idx_t'(10), acc_t'(1), pack_lanes(Q_MAX, Q_MAX, Q_MAX, Q_MAX),
              pack_lanes(Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b1);
    send_item(REQ_STEP, idx_t'(15), ACC_MAX, pack_lanes(Q_MIN, Q_MIN, Q_MIN, Q_MIN),
              pack_lanes(Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b0);
    send_step(pack_lanes(Q_MAX, Q_MIN, Q_MAX, Q_MIN),
              pack_lanes(Q_MIN, Q_MAX, Q_MIN, Q_MAX), 1'b1);

    // saturation towards the negative and positive limits in one tile
    send_preload(idx_t'(3), ACC_MIN);
    send_preload(idx_t'(12), ACC_MAX);
    send_step(pack_lanes(Q_MAX, '0, '0, Q_MAX), pack_lanes(Q_MAX, '0, '0, Q_MIN), 1'b1);

    // all-zero tile straight after a flush
    send_step('0, '0, 1'b1);

    // preloads in the middle of a tile, one overwriting the other
    send_step(rand_lanes(), rand_lanes(), 1'b0);
    send_preload(idx_t'(6), rand_acc());
    send_preload(idx_t'(6), ACC_MAX);
    send_preload(idx_t'(9), ACC_MIN);
    send_step(rand_lanes(), rand_lanes(), 1'b0);
    send_step(pack_lanes(Q_MIN, Q_MAX, Q_MIN, Q_MAX), rand_lanes(), 1'b1);

    // depth limit: a full-depth tile with no marked last step, no idling
    calm = 1'b1;
    for (k = 0; k < MAX_DEPTH; k++) send_step(rand_lanes(), rand_lanes(), 1'b0);
    calm = 1'b0;

    while (n_preloads + n_steps < ITEM_TARGET) run_random_tile();

    @(negedge clk);
    in_valid = 1'b0;
    while (rows_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d transactions: %0d preloads, %0d steps, one full-depth tile",
             n_preloads + n_steps, n_preloads, n_steps);
    $display("%0d tile rows compared, %0d mismatches", rows_checked, fail_count);
    if (fail_count == 0) begin
      $display("tile_mac_4x4_top_tb passed");
    end else begin
      $display("tile_mac_4x4_top_tb failed");
    end
    $finish;
  end

endmodule

[tile_mac_4x4_top.f]
sv/tm44_pkg.sv
sv/tile_mac_4x4_top.sv
tb/tile_mac_4x4_checker.sv
tb/tile_mac_4x4_top_tb.sv
